// File: src/pqdm_pkg.sv
`timescale 1ns / 1ps

package pqdm_pkg;

  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic               valid;
    status_e            status;
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
    logic [OCC_W-1:0]   occ;
  } result_t;

endpackage

// File: src/priority_queue_delete_max.sv
`timescale 1ns / 1ps

// Channel   Ports                                               Handshake
// request   req_type_i, entry_priority_i, entry_value_i         start high, busy low
// result    status_o, removed_priority_o, removed_value_o,      done_o high for one cycle
//           occupancy_o
//
// An insert or a rejected request is answered in the cycle after its beat, and busy stays low.
// A delete scans the n entries for the maximum, then shifts those above it down one in the
// one-read, one-write store port: the scan reads one entry a cycle, the shift moves one a cycle.
// Reset empties the queue at once; the store contents are not cleared.
// The receiver cannot stall; done_o flags each result for exactly one cycle.
module priority_queue_delete_max #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type_i,
  input  logic [pqdm_pkg::PRIO_W-1:0]          entry_priority_i,
  input  logic [pqdm_pkg::VALUE_W-1:0]         entry_value_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [pqdm_pkg::PRIO_W-1:0]          removed_priority_o,
  output logic [pqdm_pkg::VALUE_W-1:0]         removed_value_o,
  output logic [pqdm_pkg::OCC_W-1:0]           occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  pqdm_pkg::entry_t   wdata;
  pqdm_pkg::entry_t   rdata;
  pqdm_pkg::result_t  res;
  pqdm_pkg::result_t  res_q;
  logic               done_q;

  pqdm_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pqdm_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (pqdm_pkg::req_e'(req_type_i)),
    .prio_i  (entry_priority_i),
    .value_i (entry_value_i),
    .busy_o  (busy),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res;
    end
  end

  assign done_o             = done_q;
  assign status_o           = res_q.status;
  assign removed_priority_o = res_q.prio;
  assign removed_value_o    = res_q.value;
  assign occupancy_o        = res_q.occ;

endmodule

// File: src/pqdm_store.sv
`timescale 1ns / 1ps

module pqdm_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  pqdm_pkg::entry_t             wdata_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output pqdm_pkg::entry_t             rdata_o
);

  pqdm_pkg::entry_t mem_q [DEPTH];
  pqdm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pqdm_ctrl.sv
`timescale 1ns / 1ps

module pqdm_ctrl #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  pqdm_pkg::req_e                       req_i,
  input  logic [pqdm_pkg::PRIO_W-1:0]          prio_i,
  input  logic [pqdm_pkg::VALUE_W-1:0]         value_i,
  output logic                                 busy_o,
  output logic                                 we_o,
  output logic [AW-1:0]                        waddr_o,
  output pqdm_pkg::entry_t                     wdata_o,
  output logic [AW-1:0]                        raddr_o,
  input  pqdm_pkg::entry_t                     rdata_i,
  output pqdm_pkg::result_t                    res_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    cmp_q, cmp_d;
  logic [CW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    wr_q, wr_d;
  logic [CW-1:0]    best_idx_q, best_idx_d;
  pqdm_pkg::entry_t best_q, best_d;

  logic             take;
  logic             scan_last;
  logic [CW-1:0]    scan_idx;
  logic [CW-1:0]    next_rd;
  pqdm_pkg::entry_t scan_best;

  assign take      = (cmp_q == '0) || (rdata_i.prio > best_q.prio);
  assign scan_best = take ? rdata_i : best_q;
  assign scan_idx  = take ? cmp_q : best_idx_q;
  assign scan_last = (cmp_q == count_q - CW'(1));
  assign next_rd   = scan_idx + CW'(1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cmp_d      = cmp_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    we_o       = 1'b0;
    waddr_o    = '0;
    wdata_o    = rdata_i;
    raddr_o    = rd_q[AW-1:0];
    res_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        raddr_o = '0;
        if (start_i) begin
          if (req_i == pqdm_pkg::REQ_INSERT) begin
            res_o.valid = 1'b1;
            if (count_q < CW'(DEPTH)) begin
              we_o         = 1'b1;
              waddr_o      = count_q[AW-1:0];
              wdata_o.prio  = prio_i;
              wdata_o.value = value_i;
              count_d      = count_q + CW'(1);
              res_o.status = pqdm_pkg::STATUS_OK;
              res_o.occ    = pqdm_pkg::OCC_W'(count_q + CW'(1));
            end else begin
              res_o.status = pqdm_pkg::STATUS_FULL;
              res_o.occ    = pqdm_pkg::OCC_W'(count_q);
            end
          end else if (count_q == '0) begin
            res_o.valid  = 1'b1;
            res_o.status = pqdm_pkg::STATUS_EMPTY;
            res_o.occ    = '0;
          end else begin
            state_d = ST_SCAN;
            cmp_d   = '0;
            rd_d    = CW'(1);
          end
        end
      end
      ST_SCAN: begin
        best_d     = scan_best;
        best_idx_d = scan_idx;
        cmp_d      = cmp_q + CW'(1);
        rd_d       = rd_q + CW'(1);
        if (scan_last) begin
          raddr_o = next_rd[AW-1:0];
          wr_d    = scan_idx;
          rd_d    = next_rd + CW'(1);
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (wr_q + CW'(1) < count_q) begin
          we_o    = 1'b1;
          waddr_o = wr_q[AW-1:0];
          wdata_o = rdata_i;
          wr_d    = wr_q + CW'(1);
          rd_d    = rd_q + CW'(1);
        end else begin
          res_o.valid  = 1'b1;
          res_o.status = pqdm_pkg::STATUS_OK;
          res_o.prio   = best_q.prio;
          res_o.value  = best_q.value;
          res_o.occ    = pqdm_pkg::OCC_W'(count_q - CW'(1));
          count_d      = count_q - CW'(1);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q      <= cmp_d;
    rd_q       <= rd_d;
    wr_q       <= wr_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Entry count exceeds the store depth.");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !we_o)
    else $error("Store written during the maximum scan.");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && we_o) |-> (rd_q != wr_q))
    else $error("Shift writes the entry it is reading.");

  a_empty_delete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i && req_i == pqdm_pkg::REQ_DELETE && count_q == '0)
    |-> (res_o.valid && res_o.status == pqdm_pkg::STATUS_EMPTY))
    else $error("Delete on an empty queue not flagged.");

  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && res_o.valid) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("Delete did not reduce the entry count by one.");

endmodule
